[rtl/hsop_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsop_pkg: shared types and constants for the hash seeded order permutation
// Holds the per-cycle step command that the sequencer hands to each list
// builder, and the fixed widths of the hash and of the list indexes.
// ----------------------------------------------------------------------------
package hsop_pkg;

   localparam int HASH_W   = 256;
   localparam int NIB_W    = 4;
   localparam int NIB_NUM  = HASH_W / NIB_W;
   localparam int IDX_W    = 4;
   localparam int SLOT_NUM = 16;

   // One command per cycle from the sequencer to a list builder
   typedef struct packed {
      logic             clear;   // start a new list
      logic             walk;    // nib is a hash nibble, reduce and try it
      logic             fill;    // nib is a candidate index, try it as is
      logic [NIB_W-1:0] nib;
   } step_type;

endpackage

[rtl/hsop_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsop_list: permutation builder for one list
// Takes one hash nibble per cycle and reduces it modulo the list size, or one
// fill candidate as is, and appends the index to the permutation if unused.
// ----------------------------------------------------------------------------
module hsop_list #(
   parameter int COUNT = 15
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hsop_pkg::step_type          step,
   input  logic [hsop_pkg::IDX_W-1:0]  rd_pos,
   output logic [hsop_pkg::IDX_W-1:0]  rd_idx,
   output logic                        full
);

   localparam int N = (COUNT < 1) ? 1 : ((COUNT > 16) ? 16 : COUNT);

   logic [hsop_pkg::IDX_W-1:0] mod_tab [hsop_pkg::SLOT_NUM];
   logic [hsop_pkg::IDX_W-1:0] perm_ff [hsop_pkg::SLOT_NUM];
   logic [hsop_pkg::SLOT_NUM-1:0] used_ff, used_in;
   logic [hsop_pkg::IDX_W:0]   count_ff, count_in;
   logic [hsop_pkg::IDX_W-1:0] sel;
   logic                       cand;
   logic                       place;

   // Constant table of nibble modulo list size
   for (genvar g = 0; g < hsop_pkg::SLOT_NUM; g++) begin : g_mod
      localparam int MOD_VAL = g % N;
      assign mod_tab[g] = hsop_pkg::IDX_W'(MOD_VAL);
   end

   assign full = (count_ff == (hsop_pkg::IDX_W+1)'(N));

   // Pick the candidate index and decide whether it is placed
   always_comb begin
      sel   = step.walk ? mod_tab[step.nib] : step.nib;
      cand  = step.walk || (step.fill && ({1'b0, step.nib} < (hsop_pkg::IDX_W+1)'(N)));
      place = cand && !full && !used_ff[sel];
      used_in  = used_ff;
      count_in = count_ff;
      if (step.clear) begin
         used_in  = '0;
         count_in = '0;
      end else if (place) begin
         used_in[sel] = 1'b1;
         count_in     = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= '0;
      end else begin
         used_ff  <= used_in;
         count_ff <= count_in;
      end
   end

   // Append the placed index at the next free slot
   always_ff @(posedge clock) begin
      if (!step.clear && place) begin
         perm_ff[count_ff[hsop_pkg::IDX_W-1:0]] <= sel;
      end
   end

   assign rd_idx = perm_ff[rd_pos];

endmodule

[rtl/hash_seeded_order_permutation_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_seeded_order_permutation_core: two permutations seeded by a hash
// Builds a core list and a second list from one 256-bit hash, one nibble a
// cycle, and emits both permutations one entry per item.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: req_valid / req_stall carry the four 64-bit hash words.
//   A request is taken only while the core is idle; req_stall is high from
//   the accepted item until its last result has been loaded for output.
//   Response channel: rsp_valid / rsp_stall carry one list entry per item,
//   core list first (CORE_COUNT items), then the second list (CN_COUNT
//   items); rsp_last marks the final one. Both counts are clamped to 1..16.
//   Sequence: the walk covers the 64 hash nibbles (both lists share the one
//   nibble shift register), the fill tries the 16 indexes in order and
//   appends the unused ones, then one result per cycle unless rsp_stall
//   holds the output register.
//   A stalled result holds in the output register and the emitter waits.
//   Reset (synchronous) returns the sequencer to idle and drops any result.
// ----------------------------------------------------------------------------
module hash_seeded_order_permutation_core #(
   parameter int CORE_COUNT = 15,
   parameter int CN_COUNT   = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_hash_word0,
   input  logic [63:0] req_hash_word1,
   input  logic [63:0] req_hash_word2,
   input  logic [63:0] req_hash_word3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_list_select,
   output logic [3:0]  rsp_position,
   output logic [3:0]  rsp_chosen_index,
   output logic        rsp_last
);

   localparam int CORE_N = (CORE_COUNT < 1) ? 1 : ((CORE_COUNT > 16) ? 16 : CORE_COUNT);
   localparam int CN_N   = (CN_COUNT < 1) ? 1 : ((CN_COUNT > 16) ? 16 : CN_COUNT);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_FILL = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [hsop_pkg::HASH_W-1:0]   hash_ff, hash_in;
   logic [5:0]                    cnt_ff, cnt_in;
   logic                          lsel_ff, lsel_in;
   logic [hsop_pkg::IDX_W-1:0]    pos_ff, pos_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_lsel_ff, rsp_lsel_in;
   logic [3:0]                    rsp_pos_ff, rsp_pos_in;
   logic [3:0]                    rsp_idx_ff, rsp_idx_in;
   logic                          rsp_last_ff, rsp_last_in;

   hsop_pkg::step_type            step;
   logic [hsop_pkg::IDX_W-1:0]    core_idx, cn_idx;
   logic                          core_full, cn_full;
   logic                          req_take;
   logic                          load_rsp;
   logic                          list_end;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign load_rsp  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign list_end  = lsel_ff ? (pos_ff == hsop_pkg::IDX_W'(CN_N - 1))
                              : (pos_ff == hsop_pkg::IDX_W'(CORE_N - 1));

   // Build the step command for both list builders
   always_comb begin
      step.clear = req_take;
      step.walk  = (state_ff == ST_WALK);
      step.fill  = (state_ff == ST_FILL);
      step.nib   = (state_ff == ST_FILL) ? cnt_ff[hsop_pkg::IDX_W-1:0]
                                         : hash_ff[hsop_pkg::HASH_W-1 -: hsop_pkg::NIB_W];
   end

   hsop_list #(.COUNT(CORE_N)) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .rd_pos (pos_ff),
      .rd_idx (core_idx),
      .full   (core_full)
   );

   hsop_list #(.COUNT(CN_N)) u_cn (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .rd_pos (pos_ff),
      .rd_idx (cn_idx),
      .full   (cn_full)
   );

   // Sequence walk, fill and emit
   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      cnt_in   = cnt_ff;
      lsel_in  = lsel_ff;
      pos_in   = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               hash_in  = {req_hash_word3, req_hash_word2, req_hash_word1, req_hash_word0};
               cnt_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            hash_in = hash_ff << hsop_pkg::NIB_W;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 6'(hsop_pkg::NIB_NUM - 1)) begin
               cnt_in   = '0;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(hsop_pkg::SLOT_NUM - 1)) begin
               cnt_in   = '0;
               lsel_in  = 1'b0;
               pos_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_rsp) begin
               pos_in = pos_ff + 1'b1;
               if (list_end) begin
                  pos_in  = '0;
                  lsel_in = 1'b1;
                  if (lsel_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: in emit, load an item when empty or taken; hold when stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_lsel_in  = rsp_lsel_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_lsel_in  = lsel_ff;
         rsp_pos_in   = pos_ff;
         rsp_idx_in   = lsel_ff ? cn_idx : core_idx;
         rsp_last_in  = lsel_ff && list_end;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         lsel_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         lsel_ff      <= lsel_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff     <= hash_in;
      rsp_lsel_ff <= rsp_lsel_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_list_select  = rsp_lsel_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_chosen_index = rsp_idx_ff;
   assign rsp_last         = rsp_last_ff;

   // An accepted item always starts the nibble walk
   a_take_walk: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_WALK))
      else $error("accepted item did not start the walk");

   // Both lists are complete before any entry is emitted
   a_emit_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (core_full && cn_full))
      else $error("emitting from an incomplete list");

   // Loading the final item of a request returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && lsel_ff && list_end) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after the last item was loaded");

endmodule
